### hw/rtl/owner_name_hash_table_assert.svh
// Assertion macros used by the owner/name hash table RTL.
`ifndef OWNER_NAME_HASH_TABLE_ASSERT_SVH
`define OWNER_NAME_HASH_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ONHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ONHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ONHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ONHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/onht_pkg.sv
// Types and constants of the owner/name hash table.
package onht_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_PROBES  = 16;

    localparam int          START_SHIFT = 12;
    localparam logic [31:0] PROBE_MULT  = 32'd127;
    localparam logic [30:0] HIT_LIMIT   = 31'h4000_0000;
    localparam int          IDX_OUT_W   = 10;

    typedef enum logic [1:0] {
        STAT_HIT      = 2'd0,
        STAT_MISS     = 2'd1,
        STAT_INSERTED = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] hash_value;
        logic [31:0]        owner_tag;
        logic [31:0]        name_tag;
        logic [31:0]        entry_handle;
    } t_req;

    typedef struct packed {
        t_status        status;
        logic [31:0]    found_handle;
        logic [9:0]     slot_index;
        logic [30:0]    hit_count;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [31:0] owner;
        logic [31:0] name;
        logic [31:0] handle;
        logic [30:0] hits;
    } t_slot;

endpackage

### hw/rtl/onht_ram.sv
// Generic simple dual-port RAM with registered read.
module onht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/owner_name_hash_table.sv
// Top level of the owner/name open-addressed hash table.
// Each request makes 1 to MAX_PROBES probes; the result is strobed the cycle after the last probe.
// No new request is taken while busy is high, so the table handles one request at a time.
// The probe loop is bound by the single read port of the slot memory.
// Reset: busy stays high for TABLE_DEPTH cycles while a pass clears every slot.
// The result is strobed on o_done for one cycle; the receiver cannot stall.
`include "owner_name_hash_table_assert.svh"

module owner_name_hash_table import onht_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_PROBES  = DEF_MAX_PROBES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_result
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(MAX_PROBES + 1);
    localparam int SLOT_W = $bits(t_slot);

    t_state           r_state, n_state;
    logic [31:0]      r_probe, n_probe;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_clr, n_clr;
    t_req             r_req, n_req;
    logic             r_done, n_done;
    t_rsp             r_result, n_result;

    logic              accept;
    logic [31:0]       start_probe;
    logic [31:0]       next_probe;
    logic [31:0]       idx_wide;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_slot             ram_wslot;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    t_slot             rd_slot;
    logic              key_match;
    logic [30:0]       hits_inc;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign start_probe = {{START_SHIFT{i_req.hash_value[31]}}, i_req.hash_value[31:START_SHIFT]};
    assign next_probe  = r_probe * PROBE_MULT;
    assign idx_wide    = 32'(r_probe[IDX_W-1:0]);
    assign rd_slot     = t_slot'(ram_rdata);
    assign key_match   = (rd_slot.owner == r_req.owner_tag) && (rd_slot.name == r_req.name_tag);
    assign hits_inc    = (rd_slot.hits < HIT_LIMIT) ? rd_slot.hits + 31'd1 : rd_slot.hits;

    onht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wslot),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_probe  <= n_probe;
        r_req    <= n_req;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_probe   = r_probe;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_req     = r_req;
        n_done    = 1'b0;
        n_result  = r_result;
        ram_we    = 1'b0;
        ram_waddr = r_probe[IDX_W-1:0];
        ram_wslot = rd_slot;
        ram_raddr = start_probe[IDX_W-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wslot = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == {IDX_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_req   = i_req;
                    n_probe = start_probe;
                    n_cnt   = '0;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_result = '{status: STAT_MISS, found_handle: '0, slot_index: '0,
                             hit_count: '0};
                ram_raddr = next_probe[IDX_W-1:0];
                priority if (r_req.command == CMD_INSERT && !rd_slot.valid) begin
                    ram_we    = 1'b1;
                    ram_wslot = '{valid: 1'b1, owner: r_req.owner_tag,
                                  name: r_req.name_tag, handle: r_req.entry_handle,
                                  hits: '0};
                    n_result.status     = STAT_INSERTED;
                    n_result.slot_index = idx_wide[IDX_OUT_W-1:0];
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_req.command == CMD_LOOKUP && !rd_slot.valid) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_req.command == CMD_LOOKUP && key_match) begin
                    ram_we         = 1'b1;
                    ram_wslot.hits = hits_inc;
                    n_result.status       = STAT_HIT;
                    n_result.found_handle = rd_slot.handle;
                    n_result.slot_index   = idx_wide[IDX_OUT_W-1:0];
                    n_result.hit_count    = hits_inc;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_cnt == CNT_W'(MAX_PROBES - 1)) begin
                    n_result.status = (r_req.command == CMD_INSERT) ? STAT_FULL : STAT_MISS;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_probe = next_probe;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `ONHT_ASSERT_NXT(a_accept_probes, i_clk, i_rst_n, accept, r_state == ST_CHECK && r_cnt == '0)
    `ONHT_ASSERT_NXT(a_done_after_check, i_clk, i_rst_n, r_state != ST_CHECK, !o_done)
    `ONHT_ASSERT_IMP(a_probe_bound, i_clk, i_rst_n, r_state == ST_CHECK, r_cnt <= CNT_W'(MAX_PROBES - 1))
    `ONHT_ASSERT_IMP(a_insert_status, i_clk, i_rst_n, o_done && (o_result.status == STAT_INSERTED || o_result.status == STAT_FULL), r_req.command == CMD_INSERT)
    `ONHT_ASSERT_IMP(a_hit_count_range, i_clk, i_rst_n, o_done && o_result.status == STAT_HIT, o_result.hit_count != '0 && o_result.hit_count <= HIT_LIMIT)

endmodule

### dv/owner_name_hash_table_checker.sv
// Predictor and result checker for the owner/name hash table.
`timescale 1ns / 1ps

module onht_table_checker import onht_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_req i_req,
    input  logic o_done,
    input  t_rsp o_result,
    output int   mismatch_count,
    output int   pending_count
);

    localparam int TBL_SLOTS = DEF_TABLE_DEPTH;
    localparam int PROBE_CAP = DEF_MAX_PROBES;

    bit          occupied [TBL_SLOTS];
    logic [31:0] owner_of [TBL_SLOTS];
    logic [31:0] name_of  [TBL_SLOTS];
    logic [31:0] handle_of[TBL_SLOTS];
    logic [30:0] hits_of  [TBL_SLOTS];

    t_rsp awaited_results[$];

    function automatic t_rsp probe_table(t_req r);
        logic [31:0] probe;
        int          k;
        bit          stop;
        t_rsp        res;
        probe = $signed(r.hash_value) >>> START_SHIFT;
        stop = 1'b0;
        res = '0;
        res.status = (r.command == CMD_INSERT) ? STAT_FULL : STAT_MISS;
        for (int i = 0; i < PROBE_CAP; i++) begin
            if (!stop) begin
                k = probe % TBL_SLOTS;
                if (r.command == CMD_INSERT) begin
                    if (!occupied[k]) begin
                        occupied[k] = 1'b1;
                        owner_of[k] = r.owner_tag;
                        name_of[k] = r.name_tag;
                        handle_of[k] = r.entry_handle;
                        hits_of[k] = '0;
                        res.status = STAT_INSERTED;
                        res.slot_index = k[IDX_OUT_W-1:0];
                        stop = 1'b1;
                    end
                end else begin
                    if (!occupied[k]) begin
                        stop = 1'b1;
                    end else if (owner_of[k] == r.owner_tag && name_of[k] == r.name_tag) begin
                        if (hits_of[k] < HIT_LIMIT) begin
                            hits_of[k] = hits_of[k] + 31'd1;
                        end
                        res.status = STAT_HIT;
                        res.found_handle = handle_of[k];
                        res.slot_index = k[IDX_OUT_W-1:0];
                        res.hit_count = hits_of[k];
                        stop = 1'b1;
                    end
                end
                probe = probe * PROBE_MULT;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        bit   bad;
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_SLOTS; i++) begin
                occupied[i] = 1'b0;
            end
            awaited_results.delete();
            mismatch_count <= 0;
            pending_count <= 0;
        end else begin
            if (o_done) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected result status=%0d handle=%h slot=%0d hits=%0d",
                                 $realtime, o_result.status, o_result.found_handle,
                                 o_result.slot_index, o_result.hit_count);
                    end
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    bad = (o_result.status !== want.status)
                        || (o_result.found_handle !== want.found_handle)
                        || (o_result.slot_index !== want.slot_index)
                        || (o_result.hit_count !== want.hit_count);
                    if (bad) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected status=%0d handle=%h slot=%0d hits=%0d",
                                     want.status, want.found_handle, want.slot_index,
                                     want.hit_count);
                            $display("  actual   status=%0d handle=%h slot=%0d hits=%0d",
                                     o_result.status, o_result.found_handle,
                                     o_result.slot_index, o_result.hit_count);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                awaited_results.push_back(probe_table(i_req));
            end
            pending_count <= awaited_results.size();
        end
    end

endmodule

### dv/tb_owner_name_hash_table.sv
// Testbench top for the owner/name hash table: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_owner_name_hash_table;
    import onht_pkg::*;

    localparam int RANDOM_REQUESTS = 1530;
    localparam int POOL_SIZE       = 24;
    localparam int STALL_LIMIT     = 4000;

    typedef struct {
        logic [31:0] hash;
        logic [31:0] owner;
        logic [31:0] name;
    } t_key;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_rsp o_result;
    int   mismatch_count;
    int   pending_count;

    t_key        key_pool[POOL_SIZE];
    logic [9:0]  hot_slot[8];
    int          idle_cycles = 0;
    bit          burst_mode = 1'b0;

    always #1 i_clk = ~i_clk;

    owner_name_hash_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_result(o_result)
    );

    onht_table_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .o_done        (o_done),
        .o_result      (o_result),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    function automatic t_req build_request(t_cmd cmd, logic [31:0] hash, logic [31:0] owner,
                                           logic [31:0] name, logic [31:0] handle);
        t_req r;
        r.command = cmd;
        r.hash_value = hash;
        r.owner_tag = owner;
        r.name_tag = name;
        r.entry_handle = handle;
        return r;
    endfunction

    function automatic t_key fresh_key();
        t_key k;
        k.hash = $urandom;
        if ($urandom_range(1, 0) == 1) begin
            k.hash[21:12] = hot_slot[$urandom_range(7, 0)];
        end
        k.owner = $urandom_range(3, 0) == 0 ? $urandom : $urandom_range(7, 0);
        k.name = $urandom;
        return k;
    endfunction

    // hold start through back-to-back requests; drop it only for a gap
    task automatic send_request(t_req r);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(9, 0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_request();
        t_key   k;
        int     pick;
        int     roll;
        t_req   r;
        pick = $urandom_range(POOL_SIZE - 1, 0);
        roll = $urandom_range(99, 0);
        if (roll < 40) begin
            if ($urandom_range(1, 0) == 1) begin
                k = key_pool[pick];
            end else begin
                k = fresh_key();
                key_pool[pick] = k;
            end
            r = build_request(CMD_INSERT, k.hash, k.owner, k.name, $urandom);
        end else begin
            k = key_pool[pick];
            roll = $urandom_range(99, 0);
            if (roll < 15) begin
                k.owner = k.owner ^ (32'd1 << $urandom_range(31, 0));
            end else if (roll < 25) begin
                k.name = k.name ^ (32'd1 << $urandom_range(31, 0));
            end else if (roll < 40) begin
                k.hash = $urandom;
                k.owner = $urandom;
                k.name = $urandom;
            end
            r = build_request(CMD_LOOKUP, k.hash, k.owner, k.name, $urandom);
        end
        send_request(r);
    endtask

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < 8; i++) begin
            hot_slot[i] = 10'($urandom);
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = fresh_key();
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(build_request(CMD_LOOKUP, 32'h0000_0000, 32'd1, 32'd2, 32'd0));
        send_request(build_request(CMD_INSERT, 32'h0000_0000, 32'd1, 32'd2, 32'hFFFF_FFFF));
        send_request(build_request(CMD_INSERT, 32'h0000_0FFF, 32'd1, 32'd3, 32'd5));
        send_request(build_request(CMD_LOOKUP, 32'h0000_0000, 32'd1, 32'd2, 32'd0));
        send_request(build_request(CMD_LOOKUP, 32'h0000_0000, 32'd1, 32'd2, 32'd0));
        send_request(build_request(CMD_LOOKUP, 32'h0000_0000, 32'd5, 32'd2, 32'd0));
        send_request(build_request(CMD_LOOKUP, 32'h0000_0000, 32'd1, 32'd9, 32'd0));
        send_request(build_request(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'd0));
        send_request(build_request(CMD_INSERT, 32'h8000_0000, 32'd0, 32'd0, 32'h1234_5678));
        send_request(build_request(CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hA5A5_A5A5));
        send_request(build_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF));
        send_request(build_request(CMD_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'd0));
        send_request(build_request(CMD_INSERT, 32'h1234_5000, 32'd7, 32'd8, 32'd1));
        send_request(build_request(CMD_INSERT, 32'h1234_5000, 32'd7, 32'd8, 32'd2));
        send_request(build_request(CMD_LOOKUP, 32'h1234_5000, 32'd7, 32'd8, 32'd0));
        send_request(build_request(CMD_INSERT, 32'h0020_0000, 32'd3, 32'd3, 32'd3));
        send_request(build_request(CMD_INSERT, 32'h0020_0000, 32'd3, 32'd4, 32'd4));
        send_request(build_request(CMD_LOOKUP, 32'h0020_0000, 32'd3, 32'd4, 32'd0));
        send_request(build_request(CMD_LOOKUP, 32'h8000_0000, 32'd1, 32'd2, 32'd0));
        send_request(build_request(CMD_LOOKUP, 32'h5555_5000, 32'hFFFF_FFFF, 32'd0, 32'd0));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0) begin
                burst_mode = ($urandom_range(3, 0) == 0);
            end
            send_random_request();
        end
        start <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
